### sv/gse_pkg.sv
// shared types and constants for the gear rpm speed estimator
// no dependencies; imported by every module of the block
package gse_pkg;

  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned RPM_W    = 16;
  localparam int unsigned GEAR_W   = 4;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned FACTOR_W = 16;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned SETTLE_W = 16;
  localparam int unsigned PROD1_W  = RPM_W + FACTOR_W;
  localparam int unsigned PROD2_W  = SPEED_W + WEIGHT_W;

  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 17'd65536;
  localparam logic [SPEED_W-1:0]  MIN_RAW     = 16'd640;
  localparam logic [SPEED_W-1:0]  FLOOR_RAW   = 16'd64;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_GEAR_LOW  = 2'd0,
    REG_GEAR_HIGH = 2'd1,
    REG_SMOOTHING = 2'd2,
    REG_SETTLE    = 2'd3
  } gse_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIFF,
    ST_SCALE,
    ST_UPD
  } gse_state_e;

  typedef struct packed {
    logic [63:0]         gear_factors_low;
    logic [47:0]         gear_factors_high;
    logic [WEIGHT_W-1:0] smoothing;
    logic [SETTLE_W-1:0] settle_ms;
  } gse_cfg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic diff;
    logic scale;
    logic finish;
  } gse_cmd_t;

  typedef struct packed {
    logic out_busy;
  } gse_status_t;

endpackage

### sv/gse_regs.sv
// configuration registers behind an apb-style port
// depends on gse_pkg
module gse_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gse_pkg::ADDR_W-1:0] paddr,
  input  logic [gse_pkg::DATA_W-1:0] pwdata,
  output logic [gse_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output gse_pkg::gse_cfg_t         cfg_o
);
  import gse_pkg::*;

  gse_cfg_t cfg_q;
  gse_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = gse_reg_e'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gear_factors_low  <= '0;
      cfg_q.gear_factors_high <= '0;
      cfg_q.smoothing         <= FULL_WEIGHT;
      cfg_q.settle_ms         <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_GEAR_LOW:  cfg_q.gear_factors_low  <= pwdata;
        REG_GEAR_HIGH: cfg_q.gear_factors_high <= pwdata[47:0];
        REG_SMOOTHING: cfg_q.smoothing         <= pwdata[WEIGHT_W-1:0];
        REG_SETTLE:    cfg_q.settle_ms         <= pwdata[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GEAR_LOW:  prdata = cfg_q.gear_factors_low;
      REG_GEAR_HIGH: prdata = {16'd0, cfg_q.gear_factors_high};
      REG_SMOOTHING: prdata = {{(DATA_W-WEIGHT_W){1'b0}}, cfg_q.smoothing};
      REG_SETTLE:    prdata = {{(DATA_W-SETTLE_W){1'b0}}, cfg_q.settle_ms};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### sv/gse_ctrl.sv
// sequencer for one tick: evaluate, difference, scale, update
// depends on gse_pkg
module gse_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  gse_pkg::gse_status_t   status_i,
  output gse_pkg::gse_cmd_t      cmd_o
);
  import gse_pkg::*;

  gse_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_UPD;
      ST_UPD:   if (!status_i.out_busy) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_EVAL:  cmd_o.eval  = 1'b1;
      ST_DIFF:  cmd_o.diff  = 1'b1;
      ST_SCALE: cmd_o.scale = 1'b1;
      ST_UPD:   cmd_o.finish = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

### sv/gse_datapath.sv
// speed datapath: gear state, settle deadline, raw speed and low-pass filter
// depends on gse_pkg
module gse_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gse_pkg::gse_cfg_t            cfg_i,
  input  gse_pkg::gse_cmd_t            cmd_i,
  output gse_pkg::gse_status_t         status_o,
  input  logic [gse_pkg::RPM_W-1:0]    rpm_i,
  input  logic [gse_pkg::GEAR_W-1:0]   gear_number_i,
  input  logic                         drive_selected_i,
  input  logic [gse_pkg::TIME_W-1:0]   now_ms_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [gse_pkg::SPEED_W-1:0]  speed_o,
  output logic                         holding_o
);
  import gse_pkg::*;

  // captured tick
  logic [RPM_W-1:0]  rpm_q;
  logic [GEAR_W-1:0] gear_q;
  logic              drive_q;
  logic [TIME_W-1:0] now_q;

  // persistent state
  logic [SPEED_W-1:0] filt_q, filt_d;
  logic [GEAR_W-1:0]  prev_gear_q;
  logic [TIME_W-1:0]  deadline_q;

  // per-tick working registers
  logic               clr_q, run_q, hold_q;
  logic [PROD1_W-1:0] prod1_q;
  logic [SPEED_W-1:0] diff_q;
  logic               neg_q;
  logic [PROD2_W-1:0] prod2_q;
  logic               out_valid_q, holding_q;

  logic [FACTOR_W-1:0] factor;
  logic                changed, normal, clr_d, run_d;
  logic [TIME_W-1:0]   deadline_new;
  logic [SPEED_W-1:0]  sat_raw, raw;
  logic [WEIGHT_W-1:0] weight;
  logic [SPEED_W-1:0]  step;

  always_comb begin
    case (gear_q)
      4'd1:    factor = cfg_i.gear_factors_low[15:0];
      4'd2:    factor = cfg_i.gear_factors_low[31:16];
      4'd3:    factor = cfg_i.gear_factors_low[47:32];
      4'd4:    factor = cfg_i.gear_factors_low[63:48];
      4'd5:    factor = cfg_i.gear_factors_high[15:0];
      4'd6:    factor = cfg_i.gear_factors_high[31:16];
      default: factor = cfg_i.gear_factors_high[47:32];
    endcase
  end

  assign changed      = gear_q != prev_gear_q;
  assign deadline_new = changed ? now_q + {{(TIME_W-SETTLE_W){1'b0}}, cfg_i.settle_ms}
                                : deadline_q;
  assign normal       = (gear_q != '0) && (rpm_q != '0) && drive_q;
  assign clr_d        = (gear_q == '0) || ((rpm_q != '0) && !drive_q);
  assign run_d        = normal && (now_q >= deadline_new);

  // q10.6 raw speed with saturation and low-speed floor
  assign sat_raw = (prod1_q[PROD1_W-1:SPEED_W+10] != '0) ? '1 : prod1_q[SPEED_W+9:10];
  assign raw     = (sat_raw > MIN_RAW) ? sat_raw : FLOOR_RAW;

  assign weight = (cfg_i.smoothing > FULL_WEIGHT) ? FULL_WEIGHT : cfg_i.smoothing;
  assign step   = prod2_q[PROD2_W-2:WEIGHT_W-1];

  always_comb begin
    filt_d = filt_q;
    if (clr_q) begin
      filt_d = '0;
    end else if (run_q) begin
      filt_d = neg_q ? filt_q - step : filt_q + step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rpm_q   <= rpm_i;
      gear_q  <= gear_number_i;
      drive_q <= drive_selected_i;
      now_q   <= now_ms_i;
    end
    if (cmd_i.eval) begin
      clr_q   <= clr_d;
      run_q   <= run_d;
      hold_q  <= !clr_d && !run_d;
      prod1_q <= PROD1_W'(rpm_q) * PROD1_W'(factor);
    end
    if (cmd_i.diff) begin
      neg_q  <= raw < filt_q;
      diff_q <= (raw < filt_q) ? filt_q - raw : raw - filt_q;
    end
    if (cmd_i.scale) begin
      prod2_q <= PROD2_W'(diff_q) * PROD2_W'(weight);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_gear_q <= '0;
      deadline_q  <= '0;
      filt_q      <= '0;
      holding_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.eval && normal && changed) begin
        prev_gear_q <= gear_q;
        deadline_q  <= deadline_new;
      end
      if (cmd_i.finish) begin
        filt_q      <= filt_d;
        holding_q   <= hold_q;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign speed_o           = filt_q;
  assign holding_o         = holding_q;

endmodule

### sv/gear_rpm_speed_estimator.sv
// top level of the gear rpm speed estimator
// depends on gse_pkg, gse_regs, gse_ctrl, gse_datapath
//
// Each accepted tick (rpm, gear, drive flag, millisecond time) yields exactly
// one result: the filtered vehicle speed in q10.6 km/h and a holding flag.
// The raw speed is rpm times the per-gear q0.16 factor, shifted down by 10,
// saturated at 65535 and floored to 1 km/h at or below 10 km/h; a gear change
// starts a settle hold of settle_ms, after which a first-order low-pass
// filter with weight smoothing moves the speed toward the raw value. Gear 0
// or a non-drive lever clears the speed, rpm 0 holds it. One tick occupies
// the block through a capture step, then evaluate (gear decode and
// the rpm by factor multiply), difference, scale (the difference by weight
// multiply) and update; both multiplies are registered. The
// result sits in an output register, so a stalled result only delays the
// update step of the following tick. Configuration is an apb-style port
// with 64-bit data; registers lie at byte addresses 0, 8, 16 and 24
// (gear factors low, gear factors high, smoothing, settle time), decoded
// from paddr[4:3]. pready is always high.
module gear_rpm_speed_estimator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // apb-style configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gse_pkg::ADDR_W-1:0]   paddr,
  input  logic [gse_pkg::DATA_W-1:0]   pwdata,
  output logic [gse_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  // tick input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gse_pkg::RPM_W-1:0]    rpm_i,
  input  logic [gse_pkg::GEAR_W-1:0]   gear_number_i,
  input  logic                         drive_selected_i,
  input  logic [gse_pkg::TIME_W-1:0]   now_ms_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gse_pkg::SPEED_W-1:0]  speed_o,
  output logic                         holding_o
);
  import gse_pkg::*;

  gse_cfg_t    cfg;
  gse_cmd_t    cmd;
  gse_status_t status;

  gse_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: one tick at a time, waits in update while the result is stalled
  gse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: owns filter state, gear tracking and the output register
  gse_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .rpm_i            (rpm_i),
    .gear_number_i    (gear_number_i),
    .drive_selected_i (drive_selected_i),
    .now_ms_i         (now_ms_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .speed_o          (speed_o),
    .holding_o        (holding_o)
  );

  // a tick transfer is followed by a busy cycle, never by a second transfer
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input transfer accepted while a tick is in progress");

  // finishing a tick always presents a result
  a_finish_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("finished tick did not raise out_valid_o");

  // a held result carries the speed from before the tick
  a_hold_keeps_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish ##1 holding_o |-> speed_o == $past(speed_o))
    else $error("speed changed on a held result");

endmodule

### dv/gear_rpm_speed_estimator_tb.sv
// self-checking testbench for the gear rpm speed estimator: directed ticks, then random phases
// depends on gse_pkg and gear_rpm_speed_estimator; reads no files, needs no arguments
module gear_rpm_speed_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gse_pkg::*;

  // run limits, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned PHASE_ITEMS  = 190;
  // receiver hold-off used to back the block up into its input
  localparam int unsigned LONG_HOLD    = 150;
  // extra wait after the last owed result comes out, to cover any tail
  localparam int unsigned DRAIN_CYCLES = 12;

  // one input tick as the ports carry it
  typedef struct packed {
    logic [RPM_W-1:0]  rpm;
    logic [GEAR_W-1:0] gear;
    logic              drive;
    logic [TIME_W-1:0] now;
  } tick_t;

  // one result transfer
  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               holding;
  } speed_res_t;

  // directed row: tick plus an optional typed-in result
  typedef struct packed {
    tick_t      tick;
    logic       typed;
    speed_res_t res;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [RPM_W-1:0]     rpm_i;
  logic [GEAR_W-1:0]    gear_number_i;
  logic                 drive_selected_i;
  logic [TIME_W-1:0]    now_ms_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [SPEED_W-1:0]   speed_o;
  logic                 holding_o;

  // configuration as the estimator model sees it
  logic [63:0]          cfg_factors_low;
  logic [47:0]          cfg_factors_high;
  logic [WEIGHT_W-1:0]  cfg_weight;
  logic [SETTLE_W-1:0]  cfg_settle;

  // estimator model state
  logic [SPEED_W-1:0]   est_speed;
  logic [GEAR_W-1:0]    est_gear;
  logic [TIME_W-1:0]    est_deadline;

  // speeds still owed by the block, oldest first
  speed_res_t           speed_exp_q[$];
  int unsigned          mismatch_cnt;

  // idling control shared by the sender and the receiver process
  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;
  bit                   hold_off_req;

  // random drive-cycle state: current gear, clock and time step
  logic [GEAR_W-1:0]    run_gear;
  logic [TIME_W-1:0]    run_now;
  int unsigned          run_step;

  dir_row_t             dir_rows[25];

  gear_rpm_speed_estimator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rpm_i            (rpm_i),
    .gear_number_i    (gear_number_i),
    .drive_selected_i (drive_selected_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .speed_o          (speed_o),
    .holding_o        (holding_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // q0.16 km/h-per-rpm factor of a nonzero gear; gears above 6 share one slot
  function automatic logic [FACTOR_W-1:0] gear_factor(logic [GEAR_W-1:0] g);
    case (g)
      4'd1, 4'd2, 4'd3, 4'd4: gear_factor = cfg_factors_low[(g - 1) * FACTOR_W +: FACTOR_W];
      4'd5:                   gear_factor = cfg_factors_high[15:0];
      4'd6:                   gear_factor = cfg_factors_high[31:16];
      default:                gear_factor = cfg_factors_high[47:32];
    endcase
  endfunction

  // advance the estimator model by one tick and return the result it owes
  function automatic speed_res_t predict_speed(tick_t t);
    logic [31:0]         raw;
    logic [WEIGHT_W-1:0] w;
    logic [63:0]         delta;
    speed_res_t          r;
    r.holding = 1'b0;
    if (t.gear == '0) begin
      est_speed = '0;
    end else if (t.rpm == '0) begin
      // unknown rpm keeps the last speed, drive lever ignored
      r.holding = 1'b1;
    end else if (!t.drive) begin
      est_speed = '0;
    end else begin
      if (t.gear != est_gear) begin
        est_gear     = t.gear;
        est_deadline = t.now + TIME_W'(cfg_settle);
      end
      // plain unsigned compare, so wrapped deadlines release at once
      if (t.now >= est_deadline) begin
        raw = (32'(t.rpm) * 32'(gear_factor(t.gear))) >> 10;
        if (raw > 32'hFFFF) raw = 32'hFFFF;
        if (raw <= 32'(MIN_RAW)) raw = 32'(FLOOR_RAW);
        w = (cfg_weight > FULL_WEIGHT) ? FULL_WEIGHT : cfg_weight;
        // step size truncates toward zero in both directions
        if (raw >= 32'(est_speed)) begin
          delta     = (64'(raw - 32'(est_speed)) * 64'(w)) >> 16;
          est_speed = est_speed + delta[SPEED_W-1:0];
        end else begin
          delta     = (64'(32'(est_speed) - raw) * 64'(w)) >> 16;
          est_speed = est_speed - delta[SPEED_W-1:0];
        end
      end else begin
        r.holding = 1'b1;
      end
    end
    r.speed = est_speed;
    return r;
  endfunction

  function automatic logic [FACTOR_W-1:0] pick_factor(bit realistic);
    return realistic ? FACTOR_W'($urandom_range(0, 2047)) : FACTOR_W'($urandom);
  endfunction

  // mostly a plausible drive: steady gear, rising clock, some noise ticks
  function automatic tick_t next_tick();
    tick_t t;
    if ($urandom_range(99) < 8) begin
      t = {RPM_W'($urandom), GEAR_W'($urandom), 1'($urandom), TIME_W'($urandom)};
      return t;
    end
    if ($urandom_range(99) < 10) run_gear = GEAR_W'($urandom_range(1, 15));
    case ($urandom_range(99))
      0:       run_now = $urandom;
      1, 2:    run_now = 32'hFFFF_FFFF - $urandom_range(0, 4000);
      default: run_now = run_now + $urandom_range(0, run_step);
    endcase
    t.gear  = ($urandom_range(99) < 3) ? '0 : run_gear;
    t.drive = ($urandom_range(99) < 95);
    case ($urandom_range(9))
      0:          t.rpm = '0;
      1, 2:       t.rpm = RPM_W'($urandom_range(1, 500));
      3, 4, 5, 6: t.rpm = RPM_W'($urandom_range(1, 8000));
      default:    t.rpm = RPM_W'($urandom);
    endcase
    t.now = run_now;
    return t;
  endfunction

  // apb write: setup cycle, access cycle, register taken while pready is high
  task automatic write_reg(gse_reg_e idx, logic [DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_GEAR_LOW:  cfg_factors_low  = val;
      REG_GEAR_HIGH: cfg_factors_high = val[47:0];
      REG_SMOOTHING: cfg_weight       = val[WEIGHT_W-1:0];
      REG_SETTLE:    cfg_settle       = val[SETTLE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(logic [63:0] lo, logic [47:0] hi, logic [WEIGHT_W-1:0] w,
                           logic [SETTLE_W-1:0] s);
    write_reg(REG_GEAR_LOW, lo);
    write_reg(REG_GEAR_HIGH, DATA_W'(hi));
    write_reg(REG_SMOOTHING, DATA_W'(w));
    write_reg(REG_SETTLE, DATA_W'(s));
    run_step = s / 4 + 200;
  endtask

  // offer one tick, holding it until the transfer, then book its result
  task automatic send_tick(tick_t t, bit typed, speed_res_t typed_res);
    speed_res_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    rpm_i            <= t.rpm;
    gear_number_i    <= t.gear;
    drive_selected_i <= t.drive;
    now_ms_i         <= t.now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = predict_speed(t);
    speed_exp_q.push_back(typed ? typed_res : pred);
  endtask

  // drop valid and let every owed result come out
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (speed_exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, bit realistic,
                           logic [WEIGHT_W-1:0] w, logic [SETTLE_W-1:0] s, bit squeeze);
    logic [63:0] lo;
    logic [47:0] hi;
    lo = {pick_factor(realistic), pick_factor(realistic),
          pick_factor(realistic), pick_factor(realistic)};
    hi = {pick_factor(realistic), pick_factor(realistic), pick_factor(realistic)};
    // registers only change with the block empty
    wait_idle();
    configure(lo, hi, w, s);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (squeeze) hold_off_req = 1'b1;
    repeat (PHASE_ITEMS) send_tick(next_tick(), 1'b0, '0);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_left    = LONG_HOLD;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // result checker: every result transfer against the oldest owed result
  always @(posedge clk_i) begin
    speed_res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (speed_exp_q.size() == 0) begin
        $error("unexpected result: speed %0d holding %0b", speed_o, holding_o);
        mismatch_cnt++;
      end else begin
        exp_res = speed_exp_q.pop_front();
        if (speed_o !== exp_res.speed) begin
          $error("speed: expected %0d, actual %0d", exp_res.speed, speed_o);
          mismatch_cnt++;
        end
        if (holding_o !== exp_res.holding) begin
          $error("holding: expected %0b, actual %0b", exp_res.holding, holding_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog against a hung handshake
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("gear_rpm_speed_estimator_tb: FAIL");
    $finish;
  end

  initial begin
    // every input known from time zero, reset held low
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid_i       = 1'b0;
    rpm_i            = '0;
    gear_number_i    = '0;
    drive_selected_i = 1'b0;
    now_ms_i         = '0;
    send_idle_pct    = 15;
    recv_idle_pct    = 72;
    hold_off_req     = 1'b0;
    mismatch_cnt     = 0;
    run_gear         = 4'd1;
    run_now          = '0;
    run_step         = 200;

    // model starts from the reset state of the block
    cfg_factors_low  = '0;
    cfg_factors_high = '0;
    cfg_weight       = FULL_WEIGHT;
    cfg_settle       = '0;
    est_speed        = '0;
    est_gear         = '0;
    est_deadline     = '0;

    // directed ticks: rpm, gear, drive, ms, typed, speed, holding
    // gear factors: 1 0x0400, 2 0x0001, 3 0x1234, 4 0xffff, 5 0x2000, 6 0x8000, other 0x0abc
    dir_rows = '{
      // no gear clears, unknown rpm holds, lever out of drive clears
      {16'd1000,  4'd0,  1'b1, 32'd0,          1'b1, 16'd0,      1'b0},
      {16'd0,     4'd1,  1'b1, 32'd5,          1'b1, 16'd0,      1'b1},
      {16'hFFFF,  4'd1,  1'b0, 32'd6,          1'b1, 16'd0,      1'b0},
      {16'd0,     4'd15, 1'b0, 32'd7,          1'b1, 16'd0,      1'b1},
      // gear change starts a 100 ms hold, released exactly at the deadline
      {16'd1000,  4'd1,  1'b1, 32'd10,         1'b1, 16'd0,      1'b1},
      {16'd1000,  4'd1,  1'b1, 32'd109,        1'b1, 16'd0,      1'b1},
      {16'd1000,  4'd1,  1'b1, 32'd110,        1'b0, 16'd0,      1'b0},
      // raw overflow saturates
      {16'hFFFF,  4'd4,  1'b1, 32'd200,        1'b0, 16'd0,      1'b0},
      {16'hFFFF,  4'd4,  1'b1, 32'd300,        1'b1, 16'hFFFF,   1'b0},
      // tiny raw speed floors to 1 km/h
      {16'd1,     4'd2,  1'b1, 32'd400,        1'b0, 16'd0,      1'b0},
      {16'd1,     4'd2,  1'b1, 32'd500,        1'b1, 16'd64,     1'b0},
      {16'd40000, 4'd3,  1'b1, 32'd600,        1'b0, 16'd0,      1'b0},
      {16'd40000, 4'd3,  1'b1, 32'd700,        1'b0, 16'd0,      1'b0},
      {16'd30000, 4'd5,  1'b1, 32'd800,        1'b0, 16'd0,      1'b0},
      {16'd30000, 4'd5,  1'b1, 32'd900,        1'b0, 16'd0,      1'b0},
      {16'd30000, 4'd6,  1'b1, 32'd1000,       1'b0, 16'd0,      1'b0},
      {16'd30000, 4'd6,  1'b1, 32'd1100,       1'b0, 16'd0,      1'b0},
      // gears above 6 share the other-gear factor
      {16'd20000, 4'd7,  1'b1, 32'd1200,       1'b0, 16'd0,      1'b0},
      {16'd20000, 4'd7,  1'b1, 32'd1300,       1'b0, 16'd0,      1'b0},
      {16'hFFFF,  4'd15, 1'b1, 32'd1400,       1'b0, 16'd0,      1'b0},
      {16'hFFFF,  4'd15, 1'b1, 32'd1500,       1'b0, 16'd0,      1'b0},
      // deadline wraps past 2^32: released at once, then the wrapped clock holds
      {16'd50000, 4'd1,  1'b1, 32'hFFFF_FFC0,  1'b0, 16'd0,      1'b0},
      {16'd50000, 4'd1,  1'b1, 32'h0000_0010,  1'b0, 16'd0,      1'b0},
      {16'd50000, 4'd1,  1'b1, 32'h0000_0024,  1'b0, 16'd0,      1'b0},
      {16'd0,     4'd0,  1'b0, 32'hFFFF_FFFF,  1'b1, 16'd0,      1'b0}
    };

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part: oversized weight acts as no smoothing, 100 ms settle
    wait_idle();
    configure(64'hFFFF_1234_0001_0400, 48'h0ABC_8000_2000, 17'h1FFFF, 16'd100);
    foreach (dir_rows[i]) send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].res);

    // busy sender, slow receiver
    run_phase(15, 72, 1'b0, FULL_WEIGHT, 16'd0, 1'b0);
    run_phase(15, 72, 1'b1, 17'd0, 16'd300, 1'b0);
    // slow sender, busy receiver
    run_phase(72, 15, 1'b1, WEIGHT_W'($urandom_range(1, 65535)), 16'hFFFF, 1'b0);
    run_phase(72, 15, 1'b0, 17'h1FFFF, SETTLE_W'($urandom_range(0, 2000)), 1'b0);
    // back to back, first with a long receiver hold-off to fill the block
    run_phase(0, 0, 1'b1, 17'd65535, SETTLE_W'($urandom_range(0, 2000)), 1'b1);
    run_phase(0, 0, 1'b1, WEIGHT_W'($urandom_range(1, 65536)), SETTLE_W'($urandom), 1'b0);

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("gear_rpm_speed_estimator_tb: PASS");
    end else begin
      $display("gear_rpm_speed_estimator_tb: FAIL");
    end
    $finish;
  end

endmodule
